FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the hall tracker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define HCT_CHECK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define HCT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/hct_pkg.sv
// ----------------------------------------------------------------------------
// hct_pkg
// Types, constants and tables shared by the hall tracker modules.
// ----------------------------------------------------------------------------
package hct_pkg;

  localparam int unsigned SPEED_WINDOW = 60;
  localparam int unsigned LED_EVERY    = 30;
  localparam int unsigned SINE_STEPS   = 192;

  localparam int CNT_W = $clog2(SPEED_WINDOW);
  localparam int LED_W = $clog2(LED_EVERY + 1);

  // shared subtractor operand width
  localparam int OPND_W = 33;

  // 1e6 in Q16.16, dividend of the speed divider
  localparam int DIV_W = 36;
  localparam logic [DIV_W-1:0] SPEED_NUM = 36'd65536000000;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_PHASE_ADV    = 1'b0;
  localparam logic REG_RELOAD_SHIFT = 1'b1;

  localparam logic [7:0] PHASE_ADV_RST    = 8'd6;
  localparam logic [3:0] RELOAD_SHIFT_RST = 4'd5;

  typedef struct packed {
    logic [7:0] phase_advance;
    logic [3:0] reload_shift;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  hall_code;
    logic [31:0] time_us;
    logic [15:0] interval_ticks;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  sine_index;
    logic [15:0] step_reload;
    logic        led_toggle;
    logic        speed_updated;
    logic [31:0] speed_q16;
  } out_item_t;

  typedef struct packed {
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [OPND_W-1:0] diff;
    logic              borrow;
  } alu_rsp_t;

  function automatic logic [7:0] hall_start(input logic [2:0] code);
    logic [7:0] idx;
    unique case (code)
      3'd1:    idx = 8'd160;
      3'd2:    idx = 8'd32;
      3'd4:    idx = 8'd96;
      3'd5:    idx = 8'd128;
      3'd6:    idx = 8'd64;
      default: idx = 8'd0;
    endcase
    return idx;
  endfunction

endpackage

FILE: hw/rtl/hct_alu.sv
// ----------------------------------------------------------------------------
// hct_alu
// Shared subtract/compare unit: difference and borrow of two operands.
// ----------------------------------------------------------------------------
module hct_alu (
  input  hct_pkg::alu_req_t req,
  output hct_pkg::alu_rsp_t rsp
);

  logic [hct_pkg::OPND_W:0] full;

  assign full = {1'b0, req.a} - {1'b0, req.b};
  assign rsp.diff   = full[hct_pkg::OPND_W-1:0];
  assign rsp.borrow = full[hct_pkg::OPND_W];

endmodule

FILE: hw/rtl/hct_regs.sv
// ----------------------------------------------------------------------------
// hct_regs
// APB-style configuration registers: phase advance and reload shift.
// ----------------------------------------------------------------------------
module hct_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hct_pkg::ADDR_W-1:0]  paddr,
  input  logic [hct_pkg::DATA_W-1:0]  pwdata,
  output logic [hct_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output hct_pkg::cfg_t               cfg
);

  logic [7:0] phase_adv_r;
  logic [3:0] reload_shift_r;
  logic       reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_adv_r    <= hct_pkg::PHASE_ADV_RST;
      reload_shift_r <= hct_pkg::RELOAD_SHIFT_RST;
    end else if (wr_en) begin
      if (reg_idx == hct_pkg::REG_PHASE_ADV) begin
        phase_adv_r <= pwdata[7:0];
      end else begin
        reload_shift_r <= pwdata[3:0];
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      hct_pkg::REG_PHASE_ADV:    prdata = {24'd0, phase_adv_r};
      hct_pkg::REG_RELOAD_SHIFT: prdata = {28'd0, reload_shift_r};
      default:                   prdata = '0;
    endcase
  end

  assign cfg.phase_advance = phase_adv_r;
  assign cfg.reload_shift  = reload_shift_r;

endmodule

FILE: hw/rtl/hct_seq.sv
// ----------------------------------------------------------------------------
// hct_seq
// Sequencer and datapath registers: event counting, sine index reduction,
// period capture and bit-serial speed division on the shared subtractor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hct_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  hct_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  hct_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hct_pkg::out_item_t out_data,
  output hct_pkg::alu_req_t  alu_req,
  input  hct_pkg::alu_rsp_t  alu_rsp
);

  localparam int CNT_W     = hct_pkg::CNT_W;
  localparam int LED_W     = hct_pkg::LED_W;
  localparam int DIV_W     = hct_pkg::DIV_W;
  localparam int DIV_CNT_W = hct_pkg::DIV_CNT_W;
  localparam int OPND_W    = hct_pkg::OPND_W;

  localparam logic [CNT_W:0]   WIN_LAST = (CNT_W + 1)'(hct_pkg::SPEED_WINDOW);
  localparam logic [LED_W-1:0] LED_LAST = LED_W'(hct_pkg::LED_EVERY);

  localparam logic [2:0] HALL_ALL_LOW  = 3'd0;
  localparam logic [2:0] HALL_ALL_HIGH = 3'd7;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MOD  = 3'd1;
  localparam logic [2:0] ST_PER  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]           state_r,     state_nxt;
  logic [CNT_W-1:0]     event_cnt_r, event_cnt_nxt;
  logic [LED_W-1:0]     led_cnt_r,   led_cnt_nxt;
  logic [31:0]          last_time_r, last_time_nxt;
  logic [31:0]          speed_r,     speed_nxt;
  logic [31:0]          now_r,       now_nxt;
  logic [8:0]           acc_r,       acc_nxt;
  logic                 ok_r,        ok_nxt;
  logic [15:0]          reload_r,    reload_nxt;
  logic                 led_r,       led_nxt;
  logic                 upd_r,       upd_nxt;
  logic [31:0]          period_r,    period_nxt;
  logic [31:0]          rem_r,       rem_nxt;
  logic [DIV_W-1:0]     quot_r,      quot_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r,   div_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  hct_pkg::out_item_t   out_data_r,  out_data_nxt;

  logic             code_ok;
  logic [CNT_W:0]   cnt_inc;
  logic             window;
  logic [LED_W-1:0] led_inc;
  logic             led_hit;

  assign code_ok = (in_data.hall_code != HALL_ALL_LOW) && (in_data.hall_code != HALL_ALL_HIGH);
  assign cnt_inc = {1'b0, event_cnt_r} + 1'b1;
  assign window  = (cnt_inc == WIN_LAST);
  assign led_inc = led_cnt_r + 1'b1;
  assign led_hit = (led_inc == LED_LAST);

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    alu_req.a = '0;
    alu_req.b = '0;
    unique case (state_r)
      ST_MOD: begin
        alu_req.a = OPND_W'(acc_r);
        alu_req.b = OPND_W'(hct_pkg::SINE_STEPS);
      end
      ST_PER: begin
        alu_req.a = {1'b0, now_r};
        alu_req.b = {1'b0, last_time_r};
      end
      ST_DIV: begin
        alu_req.a = {rem_r, quot_r[DIV_W-1]};
        alu_req.b = {1'b0, period_r};
      end
      default: begin
        alu_req.a = '0;
        alu_req.b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    event_cnt_nxt = event_cnt_r;
    led_cnt_nxt   = led_cnt_r;
    last_time_nxt = last_time_r;
    speed_nxt     = speed_r;
    now_nxt       = now_r;
    acc_nxt       = acc_r;
    ok_nxt        = ok_r;
    reload_nxt    = reload_r;
    led_nxt       = led_r;
    upd_nxt       = upd_r;
    period_nxt    = period_r;
    rem_nxt       = rem_r;
    quot_nxt      = quot_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          now_nxt    = in_data.time_us;
          ok_nxt     = code_ok;
          acc_nxt    = 9'(hct_pkg::hall_start(in_data.hall_code)) + 9'(cfg.phase_advance);
          reload_nxt = in_data.interval_ticks >> cfg.reload_shift;
          led_nxt    = led_hit;
          upd_nxt    = window;
          if (code_ok) begin
            event_cnt_nxt = window ? '0 : cnt_inc[CNT_W-1:0];
            led_cnt_nxt   = (window || led_hit) ? '0 : led_inc;
            state_nxt     = ST_MOD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_MOD: begin
        if (!alu_rsp.borrow) begin
          acc_nxt = alu_rsp.diff[8:0];
        end else begin
          state_nxt = upd_r ? ST_PER : ST_DONE;
        end
      end
      ST_PER: begin
        period_nxt    = alu_rsp.diff[31:0];
        last_time_nxt = now_r;
        if (alu_rsp.diff[31:0] == 32'd0) begin
          speed_nxt = '1;
          state_nxt = ST_DONE;
        end else begin
          rem_nxt     = '0;
          quot_nxt    = hct_pkg::SPEED_NUM;
          div_cnt_nxt = DIV_CNT_W'(DIV_W);
          state_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt     = alu_rsp.borrow ? alu_req.a[31:0] : alu_rsp.diff[31:0];
        quot_nxt    = {quot_r[DIV_W-2:0], ~alu_rsp.borrow};
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == DIV_CNT_W'(1)) begin
          speed_nxt = (|quot_nxt[DIV_W-1:32]) ? '1 : quot_nxt[31:0];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (ok_r) begin
            out_data_nxt.accepted      = 1'b1;
            out_data_nxt.sine_index    = acc_r[7:0];
            out_data_nxt.step_reload   = reload_r;
            out_data_nxt.led_toggle    = led_r;
            out_data_nxt.speed_updated = upd_r;
            out_data_nxt.speed_q16     = speed_r;
          end else begin
            out_data_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      event_cnt_r <= '0;
      led_cnt_r   <= '0;
      last_time_r <= '0;
      speed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      event_cnt_r <= event_cnt_nxt;
      led_cnt_r   <= led_cnt_nxt;
      last_time_r <= last_time_nxt;
      speed_r     <= speed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    acc_r      <= acc_nxt;
    ok_r       <= ok_nxt;
    reload_r   <= reload_nxt;
    led_r      <= led_nxt;
    upd_r      <= upd_nxt;
    period_r   <= period_nxt;
    rem_r      <= rem_nxt;
    quot_r     <= quot_nxt;
    div_cnt_r  <= div_cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  `HCT_CHECK(a_reject_zero, clk, rst_n, (out_valid_r && !out_data_r.accepted) |-> (out_data_r == '0), "rejected item carries nonzero fields")
  `HCT_NEVER(a_rem_bound, clk, rst_n, (state_r == ST_DIV) && (rem_r >= period_r), "divider remainder not below period")
  `HCT_CHECK(a_sine_range, clk, rst_n, out_valid_r |-> (out_data_r.sine_index < 8'(hct_pkg::SINE_STEPS)), "sine index out of range")
  `HCT_CHECK(a_speed_match, clk, rst_n, (out_valid_r && out_data_r.speed_updated) |-> (out_data_r.speed_q16 == speed_r), "reported speed differs from stored speed")

endmodule

FILE: hw/rtl/hall_commutation_speed_tracker_top.sv
// ----------------------------------------------------------------------------
// hall_commutation_speed_tracker_top
// Takes one hall event per item and returns one result item: the sine table
// start index (hall table entry plus phase advance, modulo 192), the timer
// reload (interval ticks shifted right), an LED toggle every 30 accepted
// events and, every 60 accepted events, a new speed of 1e6 / period in
// unsigned Q16.16, saturated. Codes 0 and 7 give an all-zero result and
// leave the state untouched. Index reduction, period capture and division
// share one 33-bit subtractor under a small sequencer, one item at a time:
// a rejected code goes straight from accept to result, an ordinary event
// reduces the index by repeated subtraction, and a window-closing event
// also subtracts the period and runs a 36-step restoring division, which
// is skipped when the period is zero and the speed saturates. A new item
// is accepted the cycle after the result enters the output register.
// ----------------------------------------------------------------------------
module hall_commutation_speed_tracker_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  hct_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output hct_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hct_pkg::ADDR_W-1:0]  paddr,
  input  logic [hct_pkg::DATA_W-1:0]  pwdata,
  output logic [hct_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  hct_pkg::cfg_t     cfg;
  hct_pkg::alu_req_t alu_req;
  hct_pkg::alu_rsp_t alu_rsp;

  hct_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hct_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  hct_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .alu_req   (alu_req),
    .alu_rsp   (alu_rsp)
  );

endmodule
